// ===== hw/rtl/dclma_pkg.sv =====
package dclma_pkg;

  localparam int DEPTH_LOG2_DEF = 4;

  localparam int SAMPLE_W = 10;
  localparam int AVG_W    = 16;
  localparam int COEF_W   = 16;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [AVG_W-1:0]    avg_t;
  typedef logic [COEF_W-1:0]   coef_t;

  // register index, byte address bits [4:2]
  localparam logic [2:0] REG_CH0_QUAD = 3'd0;
  localparam logic [2:0] REG_CH0_LIN  = 3'd1;
  localparam logic [2:0] REG_CH0_OFS  = 3'd2;
  localparam logic [2:0] REG_CH1_QUAD = 3'd3;
  localparam logic [2:0] REG_CH1_LIN  = 3'd4;
  localparam logic [2:0] REG_CH1_OFS  = 3'd5;

  localparam coef_t QUAD_RST = 16'd1;
  localparam coef_t LIN_RST  = 16'd2;
  localparam coef_t OFS_RST  = 16'd3;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ACK    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/dclma_if.sv =====
interface dclma_in_if;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [dclma_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, kind, sample, input ready);
  modport sink   (input valid, kind, sample, output ready);
endinterface

interface dclma_out_if;
  logic                        valid;
  logic                        ready;
  logic [dclma_pkg::AVG_W-1:0] avg_ch0;
  logic [dclma_pkg::AVG_W-1:0] avg_ch1;
  logic                        ready_res;
  logic                        next_channel;

  modport source (output valid, avg_ch0, avg_ch1, ready_res, next_channel, input ready);
  modport sink   (input valid, avg_ch0, avg_ch1, ready_res, next_channel, output ready);
endinterface

// ===== hw/rtl/dclma_ring.sv =====
// Sample ring: one write and one registered read port; unwritten entries read as zero.
module dclma_ring #(
  parameter int DEPTH_LOG2 = dclma_pkg::DEPTH_LOG2_DEF,
  localparam int AW = (DEPTH_LOG2 > 0) ? DEPTH_LOG2 : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  dclma_pkg::sample_t  wr_data,
  input  logic [AW-1:0]       rd_addr,
  output dclma_pkg::sample_t  rd_x
);
  import dclma_pkg::*;

  localparam int DEPTH = 1 << DEPTH_LOG2;

  sample_t            mem [DEPTH];
  logic [DEPTH-1:0]   vld;
  sample_t            rd_q;
  logic               rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q   <= mem[rd_addr];
    rd_vld <= vld[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_x = rd_vld ? rd_q : '0;

endmodule

// ===== hw/rtl/dual_channel_linearized_moving_average_top.sv =====
// Channel   Kind      Transfer payload
// in_ch     sink      kind (0 sample, 1 acknowledge), sample[9:0]
// out_ch    source    avg_ch0[15:0], avg_ch1[15:0], ready_res, next_channel
// apb       slave     six 16-bit coefficient registers at 4*i
//
// Each item walks both rings in turn after its transfer: every ring entry
// passes through FETCH, MUL1 and MUL2 on the shared 16x10 multiplier
// (fetch, a*x+b, x*t+c); ST_DONE loads the output register once any
// prior result is taken. in_ch.ready is high only while the sequencer idles.
// Synchronous reset clears the rings (valid bits), pointers and flags.
// A pending result may sit in the output register while the next item runs.
module dual_channel_linearized_moving_average_top #(
  parameter int DEPTH_LOG2 = dclma_pkg::DEPTH_LOG2_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  dclma_in_if.sink                          in_ch,
  dclma_out_if.source                       out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dclma_pkg::PADDR_W-1:0]     paddr,
  input  logic [dclma_pkg::PDATA_W-1:0]     pwdata,
  output logic [dclma_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);
  import dclma_pkg::*;

  localparam int AW    = (DEPTH_LOG2 > 0) ? DEPTH_LOG2 : 1;
  localparam int DEPTH = 1 << DEPTH_LOG2;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  // ---------------------------------------------------------------------
  // Coefficient registers
  // ---------------------------------------------------------------------
  coef_t ch0_quad_coef, ch0_lin_coef, ch0_offset;
  coef_t ch1_quad_coef, ch1_lin_coef, ch1_offset;
  logic  cfg_wr;
  coef_t cfg_rd;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch0_quad_coef <= QUAD_RST;
      ch0_lin_coef  <= LIN_RST;
      ch0_offset    <= OFS_RST;
      ch1_quad_coef <= QUAD_RST;
      ch1_lin_coef  <= LIN_RST;
      ch1_offset    <= OFS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_CH0_QUAD: ch0_quad_coef <= pwdata[COEF_W-1:0];
        REG_CH0_LIN:  ch0_lin_coef  <= pwdata[COEF_W-1:0];
        REG_CH0_OFS:  ch0_offset    <= pwdata[COEF_W-1:0];
        REG_CH1_QUAD: ch1_quad_coef <= pwdata[COEF_W-1:0];
        REG_CH1_LIN:  ch1_lin_coef  <= pwdata[COEF_W-1:0];
        REG_CH1_OFS:  ch1_offset    <= pwdata[COEF_W-1:0];
        default: ; // unmapped: dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_CH0_QUAD: cfg_rd = ch0_quad_coef;
      REG_CH0_LIN:  cfg_rd = ch0_lin_coef;
      REG_CH0_OFS:  cfg_rd = ch0_offset;
      REG_CH1_QUAD: cfg_rd = ch1_quad_coef;
      REG_CH1_LIN:  cfg_rd = ch1_lin_coef;
      REG_CH1_OFS:  cfg_rd = ch1_offset;
      default:      cfg_rd = '0;
    endcase
  end

  assign prdata = {{(PDATA_W-COEF_W){1'b0}}, cfg_rd};

  // ---------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------
  state_t          state, state_next;
  logic            cur_channel;   // channel the next sample goes to
  logic            ready_flag;
  logic [AW-1:0]   ptr0, ptr1;
  logic            pass_ch;       // ring being summed
  logic [AW-1:0]   idx;
  logic            in_acc;
  logic            out_load;
  logic            out_valid;
  logic            wr_en0, wr_en1;
  logic            last;

  // datapath
  sample_t         x0, x1, x;
  coef_t           coef_a, coef_b, coef_c;
  coef_t           mul_lhs;
  logic [COEF_W+SAMPLE_W-1:0] prod_full;
  coef_t           mul_res;
  avg_t            sum_next;
  coef_t           term_q;        // a*x + b
  avg_t            acc;
  avg_t            avg0, avg1;
  avg_t            out_avg0, out_avg1;
  logic            out_rdy_res, out_next_ch;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  assign in_acc = in_ch.valid & in_ch.ready;
  assign wr_en0 = in_acc & (in_ch.kind == KIND_SAMPLE) & ~cur_channel;
  assign wr_en1 = in_acc & (in_ch.kind == KIND_SAMPLE) &  cur_channel;
  assign last   = (idx == LAST_IDX);

  dclma_ring #(.DEPTH_LOG2(DEPTH_LOG2)) u_ring0 (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en0),
    .wr_addr (ptr0),
    .wr_data (in_ch.sample),
    .rd_addr (idx),
    .rd_x    (x0)
  );

  dclma_ring #(.DEPTH_LOG2(DEPTH_LOG2)) u_ring1 (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en1),
    .wr_addr (ptr1),
    .wr_data (in_ch.sample),
    .rd_addr (idx),
    .rd_x    (x1)
  );

  // Shared multiplier: a*x in MUL1, x*(a*x+b) in MUL2, all mod 2^16.
  assign x       = pass_ch ? x1 : x0;
  assign coef_a  = pass_ch ? ch1_quad_coef : ch0_quad_coef;
  assign coef_b  = pass_ch ? ch1_lin_coef  : ch0_lin_coef;
  assign coef_c  = pass_ch ? ch1_offset    : ch0_offset;
  assign mul_lhs = (state == ST_MUL2) ? term_q : coef_a;
  assign prod_full = mul_lhs * x;
  assign mul_res   = prod_full[COEF_W-1:0];
  assign sum_next  = acc + mul_res + coef_c;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc) state_next = ST_FETCH;
      ST_FETCH: state_next = ST_MUL1;
      ST_MUL1:  state_next = ST_MUL2;
      ST_MUL2: begin
        if (last && pass_ch) state_next = ST_DONE;
        else                 state_next = ST_FETCH;
      end
      ST_DONE:  if (!out_valid || out_ch.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    out_load    = (state == ST_DONE) && (!out_valid || out_ch.ready);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cur_channel <= 1'b1;
      ready_flag  <= 1'b0;
      ptr0        <= '0;
      ptr1        <= '0;
      pass_ch     <= 1'b0;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        pass_ch <= 1'b0;
        idx     <= '0;
        if (in_ch.kind == KIND_ACK) begin
          ready_flag <= 1'b0;
        end else if (cur_channel) begin
          ptr1        <= ptr_inc(ptr1);
          ready_flag  <= 1'b1;
          cur_channel <= 1'b0;
        end else begin
          ptr0        <= ptr_inc(ptr0);
          cur_channel <= 1'b1;
        end
      end
      if (state == ST_MUL2) begin
        if (last) begin
          idx     <= '0;
          pass_ch <= 1'b1;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc <= '0;
    end
    if (state == ST_MUL1) begin
      term_q <= mul_res + coef_b;
    end
    if (state == ST_MUL2) begin
      if (last) begin
        acc <= '0;
        if (pass_ch) avg1 <= sum_next >> DEPTH_LOG2;
        else         avg0 <= sum_next >> DEPTH_LOG2;
      end else begin
        acc <= sum_next;
      end
    end
    if (out_load) begin
      out_avg0    <= avg0;
      out_avg1    <= avg1;
      out_rdy_res <= ready_flag;
      out_next_ch <= cur_channel;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.avg_ch0      = out_avg0;
  assign out_ch.avg_ch1      = out_avg1;
  assign out_ch.ready_res    = out_rdy_res;
  assign out_ch.next_channel = out_next_ch;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_FETCH)
    else $error("sequencer did not start after input transfer");

  a_channel_holds: assert property (@(posedge clk) disable iff (rst)
    !(in_acc && in_ch.kind == KIND_SAMPLE) |=> $stable(cur_channel))
    else $error("channel moved without a sample");

  a_flag_on_ch1: assert property (@(posedge clk) disable iff (rst)
    wr_en1 |=> ready_flag && !cur_channel)
    else $error("channel 1 sample did not set ready flag");

  a_single_write: assert property (@(posedge clk) disable iff (rst)
    !(wr_en0 && wr_en1))
    else $error("both rings written at once");

endmodule
